// File: design/scd_pkg.sv
package scd_pkg;

    // Line geometry and sample format
    localparam int LINE_DEPTH  = 2048;
    localparam int SAMPLE_BITS = 24;
    localparam int IDX_W       = $clog2(LINE_DEPTH);
    localparam int POS_W       = IDX_W + 8;
    localparam int SPAN        = LINE_DEPTH * 256;
    localparam int DMAX        = (LINE_DEPTH - 1) * 256;

    // Control word widths
    localparam int Q16_W    = 17;
    localparam int FULL_Q16 = 65536;
    localparam int STEP_W   = 24;
    localparam int BASE_W   = 18;
    localparam int ANGLE_W  = 32;
    localparam int DSUM_W   = BASE_W + 1;
    localparam int CMP_W    = (POS_W > DSUM_W) ? POS_W : DSUM_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef logic signed [SAMPLE_BITS-1:0] scd_sample_t;
    typedef logic [IDX_W-1:0]              scd_idx_t;
    typedef logic [Q16_W-1:0]              scd_q16_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BYPASS_ON    = 3'd0,
        REG_LFO_STEP     = 3'd1,
        REG_DEPTH_AMOUNT = 3'd2,
        REG_WET_LEVEL    = 3'd3,
        REG_BASE_DELAY   = 3'd4
    } scd_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCALE,
        ST_DELAY,
        ST_POS,
        ST_READ_A,
        ST_READ_B,
        ST_TAP_B,
        ST_INTERP,
        ST_MIX,
        ST_DONE
    } scd_state_t;

    // Per-step strobes from the sequencer to each channel lane
    typedef struct packed {
        logic     wr_en;
        logic     rd_en;
        logic     rd_known;
        logic     cap_a;
        logic     cap_b;
        logic     interp;
        logic     mix;
        scd_idx_t addr;
    } scd_lane_ctl_t;

endpackage

// File: design/scd_if.sv
interface scd_in_if;
    logic                valid;
    logic                ready;
    scd_pkg::scd_sample_t left_in;
    scd_pkg::scd_sample_t right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scd_out_if;
    logic                valid;
    logic                ready;
    scd_pkg::scd_sample_t left_out;
    scd_pkg::scd_sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface scd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [scd_pkg::CFG_IDX_W-1:0]    index;
    logic [scd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/scd_lane.sv
module scd_lane
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  scd_pkg::scd_lane_ctl_t ctl,
    input  scd_pkg::scd_sample_t   sample,
    input  logic [7:0]            frac,
    input  scd_pkg::scd_q16_t      wet,
    output scd_pkg::scd_sample_t   result
);

    localparam int SW = scd_pkg::SAMPLE_BITS;

    scd_pkg::scd_sample_t line_mem [scd_pkg::LINE_DEPTH];

    scd_pkg::scd_sample_t rd_data_reg;
    logic                 rd_ok_reg;
    scd_pkg::scd_sample_t s1_reg;
    scd_pkg::scd_sample_t s2_reg;
    scd_pkg::scd_sample_t delayed_reg;
    logic signed [SW+17:0] dry_prod_reg;
    scd_pkg::scd_sample_t result_reg;

    scd_pkg::scd_sample_t  tap;
    scd_pkg::scd_q16_t     dry_w;
    logic signed [SW+17:0] dry_prod;
    logic signed [SW:0]    diff;
    logic signed [SW+9:0]  acc;
    logic signed [SW+18:0] mix_sum;

    // Write the new sample, read one tap per cycle when the read strobe is set
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            line_mem[ctl.addr] <= sample;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= line_mem[ctl.addr];
        end
    end

    // Track whether the tap just read was ever written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ok_reg <= 1'b0;
        end
        else if (ctl.rd_en)
        begin
            rd_ok_reg <= ctl.rd_known;
        end
    end

    // Unwritten entries read as silence
    assign tap = rd_ok_reg ? rd_data_reg : '0;

    // Dry weight and dry product
    assign dry_w    = scd_pkg::Q16_W'(18'(scd_pkg::FULL_Q16) - {1'b0, wet});
    assign dry_prod = sample * $signed({1'b0, dry_w});

    // Linear interpolation between the two taps, floor of the Q.8 result
    assign diff = (SW+1)'(s2_reg) - (SW+1)'(s1_reg);
    assign acc  = ((SW+10)'(s1_reg) <<< 8) + $signed({1'b0, frac}) * diff;

    // Blend dry and wet with Q1.16 weights, floor of the result at 16 fraction bits
    assign mix_sum = (SW+19)'(dry_prod_reg) + delayed_reg * $signed({1'b0, wet});

    // Advance the lane pipeline on the sequencer's strobes
    always_ff @(posedge clk)
    begin
        if (ctl.cap_a)
        begin
            s1_reg <= tap;
        end
        if (ctl.cap_b)
        begin
            s2_reg       <= tap;
            dry_prod_reg <= dry_prod;
        end
        if (ctl.interp)
        begin
            delayed_reg <= acc[SW+7:8];
        end
        if (ctl.mix)
        begin
            result_reg <= mix_sum[SW+15:16];
        end
    end

    assign result = result_reg;

endmodule

// File: design/stereo_chorus_delay_unit.sv
// Sequencing: an accepted input word steps through the two-multiply delay chain,
//   the two single-port tap reads, interpolation and mix before its output word is
//   offered (bypass goes straight to the final step). No new input word is taken
//   until the previous output word is loaded.
// Reset: control, write pointer, LFO phase and registers return to defaults at
//   once; line entries not yet written since reset read as zero.
module stereo_chorus_delay_unit
(
    input logic        clk,
    input logic        rst_n,
    scd_in_if.sink     samples,
    scd_out_if.source  mixed,
    scd_cfg_if.sink    cfg
);

    localparam int IDX_W = scd_pkg::IDX_W;
    localparam int POS_W = scd_pkg::POS_W;

    // Configuration registers
    logic                       bypass_on_reg;
    logic [scd_pkg::STEP_W-1:0] lfo_step_reg;
    scd_pkg::scd_q16_t          depth_amount_reg;
    scd_pkg::scd_q16_t          wet_level_reg;
    logic [scd_pkg::BASE_W-1:0] base_delay_reg;

    // Sequencer and block state
    scd_pkg::scd_state_t state_reg;
    scd_pkg::scd_state_t state_next;
    scd_pkg::scd_idx_t   wi_reg;
    scd_pkg::scd_idx_t   wi_next;
    logic                full_reg;
    logic [scd_pkg::ANGLE_W-1:0] angle_reg;

    // Item and datapath registers
    scd_pkg::scd_sample_t       left_reg;
    scd_pkg::scd_sample_t       right_reg;
    logic                       bypass_item_reg;
    scd_pkg::scd_q16_t          m_reg;
    logic [scd_pkg::BASE_W-1:0] bm_reg;
    logic [POS_W-1:0]           d_reg;
    scd_pkg::scd_idx_t          i1_reg;
    scd_pkg::scd_idx_t          i2_reg;
    logic [7:0]                 frac_reg;

    // Output register
    logic                 out_valid_reg;
    scd_pkg::scd_sample_t left_out_reg;
    scd_pkg::scd_sample_t right_out_reg;

    logic                       in_acc;
    logic                       out_load;
    scd_pkg::scd_lane_ctl_t     lane_ctl;
    scd_pkg::scd_sample_t       left_mix;
    scd_pkg::scd_sample_t       right_mix;
    scd_pkg::scd_q16_t          tri_val;
    logic [16:0]                u_val;
    scd_pkg::scd_q16_t          depth_sat;
    scd_pkg::scd_q16_t          wet_sat;
    logic [33:0]                m_prod;
    logic [34:0]                bm_prod;
    logic [scd_pkg::DSUM_W-1:0] d_sum;
    logic [POS_W-1:0]           d_sat;
    logic [POS_W:0]             pos_sum;
    logic [POS_W:0]             pos_wrap;
    logic [POS_W-1:0]           pos;
    scd_pkg::scd_idx_t          i1_val;
    scd_pkg::scd_idx_t          i2_val;

    assign in_acc   = samples.valid && samples.ready;
    assign out_load = (state_reg == scd_pkg::ST_DONE) && (!out_valid_reg || mixed.ready);

    // Register writes; always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_on_reg    <= 1'b0;
            lfo_step_reg     <= scd_pkg::STEP_W'(134218);
            depth_amount_reg <= scd_pkg::Q16_W'(32768);
            wet_level_reg    <= scd_pkg::Q16_W'(32768);
            base_delay_reg   <= scd_pkg::BASE_W'(184320);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                scd_pkg::REG_BYPASS_ON:    bypass_on_reg    <= cfg.data[0];
                scd_pkg::REG_LFO_STEP:     lfo_step_reg     <= cfg.data[23:0];
                scd_pkg::REG_DEPTH_AMOUNT: depth_amount_reg <= cfg.data[16:0];
                scd_pkg::REG_WET_LEVEL:    wet_level_reg    <= cfg.data[16:0];
                scd_pkg::REG_BASE_DELAY:   base_delay_reg   <= cfg.data[17:0];
                default:                   ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scd_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = bypass_on_reg ? scd_pkg::ST_DONE : scd_pkg::ST_MOD;
                end
            end
            scd_pkg::ST_MOD:    state_next = scd_pkg::ST_SCALE;
            scd_pkg::ST_SCALE:  state_next = scd_pkg::ST_DELAY;
            scd_pkg::ST_DELAY:  state_next = scd_pkg::ST_POS;
            scd_pkg::ST_POS:    state_next = scd_pkg::ST_READ_A;
            scd_pkg::ST_READ_A: state_next = scd_pkg::ST_READ_B;
            scd_pkg::ST_READ_B: state_next = scd_pkg::ST_TAP_B;
            scd_pkg::ST_TAP_B:  state_next = scd_pkg::ST_INTERP;
            scd_pkg::ST_INTERP: state_next = scd_pkg::ST_MIX;
            scd_pkg::ST_MIX:    state_next = scd_pkg::ST_DONE;
            scd_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = scd_pkg::ST_IDLE;
                end
            end
            default:            state_next = scd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: input ready and lane strobes
    always_comb
    begin
        samples.ready = 1'b0;
        lane_ctl      = '0;
        unique case (state_reg)
            scd_pkg::ST_IDLE:
            begin
                samples.ready = 1'b1;
            end
            scd_pkg::ST_MOD:
            begin
                lane_ctl.wr_en = 1'b1;
                lane_ctl.addr  = wi_reg;
            end
            scd_pkg::ST_READ_A:
            begin
                lane_ctl.rd_en    = 1'b1;
                lane_ctl.addr     = i1_reg;
                lane_ctl.rd_known = full_reg || (i1_reg <= wi_reg);
            end
            scd_pkg::ST_READ_B:
            begin
                lane_ctl.rd_en    = 1'b1;
                lane_ctl.addr     = i2_reg;
                lane_ctl.rd_known = full_reg || (i2_reg <= wi_reg);
                lane_ctl.cap_a    = 1'b1;
            end
            scd_pkg::ST_TAP_B:  lane_ctl.cap_b  = 1'b1;
            scd_pkg::ST_INTERP: lane_ctl.interp = 1'b1;
            scd_pkg::ST_MIX:    lane_ctl.mix    = 1'b1;
            default:            ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Triangle LFO and saturated gains
    assign u_val     = angle_reg[31:15];
    assign tri_val   = (u_val <= 17'(scd_pkg::FULL_Q16)) ? u_val
                                                         : 17'(18'd131072 - {1'b0, u_val});
    assign depth_sat = (depth_amount_reg > 17'(scd_pkg::FULL_Q16)) ? 17'(scd_pkg::FULL_Q16)
                                                                   : depth_amount_reg;
    assign wet_sat   = (wet_level_reg > 17'(scd_pkg::FULL_Q16)) ? 17'(scd_pkg::FULL_Q16)
                                                                : wet_level_reg;

    // Modulated delay, one multiply per step
    assign m_prod  = tri_val * depth_sat;
    assign bm_prod = base_delay_reg * m_reg;
    assign d_sum   = {1'b0, base_delay_reg} + {1'b0, bm_reg};
    assign d_sat   = (scd_pkg::CMP_W'(d_sum) > scd_pkg::CMP_W'(scd_pkg::DMAX))
                   ? POS_W'(scd_pkg::DMAX) : POS_W'(d_sum);

    // Read position behind the write pointer, wrapped into the line
    assign pos_sum  = (POS_W+1)'({wi_reg, 8'b0}) + (POS_W+1)'(scd_pkg::SPAN)
                    - (POS_W+1)'(d_reg);
    assign pos_wrap = (pos_sum >= (POS_W+1)'(scd_pkg::SPAN))
                    ? pos_sum - (POS_W+1)'(scd_pkg::SPAN) : pos_sum;
    assign pos      = pos_wrap[POS_W-1:0];
    assign i1_val   = pos[POS_W-1:8];
    assign i2_val   = (i1_val == IDX_W'(scd_pkg::LINE_DEPTH - 1)) ? '0 : i1_val + 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            left_reg        <= samples.left_in;
            right_reg       <= samples.right_in;
            bypass_item_reg <= bypass_on_reg;
        end
        if (state_reg == scd_pkg::ST_MOD)
        begin
            m_reg <= m_prod[32:16];
        end
        if (state_reg == scd_pkg::ST_SCALE)
        begin
            bm_reg <= bm_prod[33:16];
        end
        if (state_reg == scd_pkg::ST_DELAY)
        begin
            d_reg <= d_sat;
        end
        if (state_reg == scd_pkg::ST_POS)
        begin
            i1_reg   <= i1_val;
            i2_reg   <= i2_val;
            frac_reg <= pos[7:0];
        end
    end

    // Advance write pointer, fill flag and LFO phase once the taps are read
    assign wi_next = (wi_reg == IDX_W'(scd_pkg::LINE_DEPTH - 1)) ? '0 : wi_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg    <= '0;
            full_reg  <= 1'b0;
            angle_reg <= '0;
        end
        else if (state_reg == scd_pkg::ST_INTERP)
        begin
            wi_reg    <= wi_next;
            angle_reg <= angle_reg + scd_pkg::ANGLE_W'(lfo_step_reg);
            if (wi_reg == IDX_W'(scd_pkg::LINE_DEPTH - 1))
            begin
                full_reg <= 1'b1;
            end
        end
    end

    // Channel lanes
    scd_lane u_left
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (left_reg),
        .frac   (frac_reg),
        .wet    (wet_sat),
        .result (left_mix)
    );

    scd_lane u_right
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (lane_ctl),
        .sample (right_reg),
        .frac   (frac_reg),
        .wet    (wet_sat),
        .result (right_mix)
    );

    // Merge lanes into the output word, or pass the input in bypass
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg  <= bypass_item_reg ? left_reg : left_mix;
            right_out_reg <= bypass_item_reg ? right_reg : right_mix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (mixed.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign mixed.valid     = out_valid_reg;
    assign mixed.left_out  = left_out_reg;
    assign mixed.right_out = right_out_reg;

    // Write pointer moves only in the advance step
    a_wi_moves_in_interp: assert property (@(posedge clk) disable iff (!rst_n)
        (wi_reg != $past(wi_reg)) |-> ($past(state_reg) == scd_pkg::ST_INTERP))
        else $error("write pointer moved outside the advance step");

    // Fill flag never clears once set
    a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg |=> full_reg)
        else $error("fill flag cleared");

    // Saturated delay stays inside the line while taps are read
    a_delay_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scd_pkg::ST_READ_A) |-> (d_reg <= POS_W'(scd_pkg::DMAX)))
        else $error("delay beyond line length");

    // A new output word is only loaded from the final step
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == scd_pkg::ST_DONE))
        else $error("output loaded outside final step");

endmodule
